// ===== hdl/periodic_waveform_generator_core_assert.svh =====
// Assertion macros shared by the waveform generator modules.
`ifndef PERIODIC_WAVEFORM_GENERATOR_CORE_ASSERT_SVH
`define PERIODIC_WAVEFORM_GENERATOR_CORE_ASSERT_SVH

// Property that must hold in the same cycle.
`define PWG_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Condition in one cycle implies a property in the next.
`define PWG_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

// ===== hdl/pwg_pkg.sv =====
// Package: widths, codes, types and sine quarter table of the waveform generator.
`timescale 1ns / 1ps

package pwg_pkg;

    localparam int TIME_STEP_W = 16;
    localparam int SAMPLE_W    = 32;
    localparam int AMP_W       = 16;
    localparam int MODE_W      = 2;
    localparam int TICKS_W     = 32;
    localparam int ELAPSED_W   = 33;
    localparam int CFG_IDX_W   = 4;
    localparam int CFG_DATA_W  = 32;

    localparam int SINE_TABLE_DEPTH = 1024;
    localparam int PHASE_W          = $clog2(SINE_TABLE_DEPTH);
    localparam int QUARTER_W        = PHASE_W - 2;
    localparam int QUARTER_DEPTH    = SINE_TABLE_DEPTH / 4;
    localparam int ANGLE_SHIFT      = 30 - QUARTER_W;
    localparam int SINE_W           = 16;
    localparam int SINE_FRAC        = 15;

    localparam int DIV_STEPS = ELAPSED_W + PHASE_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);
    localparam int PROD_W    = ELAPSED_W + 1 + AMP_W;

    localparam logic [MODE_W-1:0] MODE_STEP = 2'd0;
    localparam logic [MODE_W-1:0] MODE_RAMP = 2'd1;
    localparam logic [MODE_W-1:0] MODE_SINE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_MODE      = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_AMPLITUDE = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DELAY     = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD    = 4'd3;

    localparam logic [TICKS_W-1:0] PERIOD_RESET = '1;

    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ACC,
        ST_WRAP,
        ST_DIFF,
        ST_DIV,
        ST_MUL,
        ST_FORM
    } t_state;

    typedef enum logic [1:0] {
        KIND_ZERO,
        KIND_STEP,
        KIND_RAMP,
        KIND_SINE
    } t_kind;

    typedef struct packed {
        logic                 start;
        logic [ELAPSED_W-1:0] dividend;
    } t_div_req;

    typedef struct packed {
        logic               done;
        logic [PHASE_W-1:0] phase;
    } t_div_rsp;

    // Quarter-wave sine in Q1.15, Q30 Taylor series evaluated at elaboration.
    localparam int            TAYLOR_TERMS = 8;
    localparam logic [63:0]   TWO_PI_Q30   = 64'd6746518852;
    localparam logic signed [63:0] Q30_ONE = 64'sd1073741824;
    localparam logic [63:0]   TAYLOR_DIV [TAYLOR_TERMS] =
        '{64'd1, 64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210};

    typedef logic signed [SINE_W-1:0] t_sine_quarter [QUARTER_DEPTH];

    function automatic logic signed [SINE_W-1:0] sine_q15_quarter(input int unsigned k);
        logic [63:0]        u;
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [63:0] sum;
        logic [63:0]        s;
        u    = 64'(k) << ANGLE_SHIFT;
        x    = (u * TWO_PI_Q30) >> 32;
        x2   = (x * x) >> 30;
        term = x;
        sum  = signed'(x);
        for (int n = 1; n < TAYLOR_TERMS; n++) begin
            term = ((term * x2) >> 30) / TAYLOR_DIV[n];
            if ((n & 1) == 1) begin
                sum = sum - signed'(term);
            end else begin
                sum = sum + signed'(term);
            end
        end
        if (sum < 64'sd0) begin
            sum = 64'sd0;
        end
        if (sum > Q30_ONE) begin
            sum = Q30_ONE;
        end
        s = (unsigned'(sum) * 64'd32767 + 64'd536870912) >> 30;
        return SINE_W'(s);
    endfunction

    function automatic t_sine_quarter build_sine_quarter();
        t_sine_quarter tab;
        for (int k = 0; k < QUARTER_DEPTH; k++) begin
            tab[k] = sine_q15_quarter(k);
        end
        return tab;
    endfunction

    localparam t_sine_quarter           SINE_QUARTER = build_sine_quarter();
    localparam logic signed [SINE_W-1:0] SINE_PEAK   = sine_q15_quarter(QUARTER_DEPTH);

endpackage

// ===== hdl/pwg_if.sv =====
// Interfaces: time step input, sample output and configuration write channels.
`timescale 1ns / 1ps

interface pwg_in_if import pwg_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [TIME_STEP_W-1:0] time_step;
    modport source (output valid, output time_step, input ready);
    modport sink (input valid, input time_step, output ready);
endinterface

interface pwg_out_if import pwg_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample;
    modport source (output valid, output sample, input ready);
    modport sink (input valid, input sample, output ready);
endinterface

interface pwg_cfg_if import pwg_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// ===== hdl/pwg_phase_div.sv =====
// Radix-2 restoring divider giving the sine phase index, one quotient bit per cycle.
`timescale 1ns / 1ps
`include "periodic_waveform_generator_core_assert.svh"

module pwg_phase_div import pwg_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_div_req           i_req,
    input  logic [TICKS_W-1:0] i_divisor,
    output t_div_rsp           o_rsp
);

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DIV_STEPS-1:0] r_num;
    logic [TICKS_W-1:0]   r_rem;
    logic [PHASE_W-1:0]   r_quo;

    logic [TICKS_W:0] w_trial;
    logic [TICKS_W:0] w_sub;
    logic             w_ge;

    assign w_trial = {r_rem, r_num[DIV_STEPS-1]};
    assign w_sub   = w_trial - {1'b0, i_divisor};
    assign w_ge    = (w_trial >= {1'b0, i_divisor});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_num <= {i_req.dividend, PHASE_W'(0)};
            r_rem <= '0;
        end else if (r_busy) begin
            r_num <= {r_num[DIV_STEPS-2:0], 1'b0};
            r_rem <= w_ge ? w_sub[TICKS_W-1:0] : w_trial[TICKS_W-1:0];
            r_quo <= {r_quo[PHASE_W-2:0], w_ge};
        end
    end

    assign o_rsp.done  = r_done;
    assign o_rsp.phase = r_quo;

    `PWG_ASSERT(a_start_idle, i_clk, i_rst_n, !i_req.start || !r_busy, "divider started while busy")
    `PWG_ASSERT(a_done_after_busy, i_clk, i_rst_n, !r_done || $past(r_busy), "done without a run")
    `PWG_ASSERT_NEXT(a_cnt_steps, i_clk, i_rst_n, r_busy, !r_busy || (r_cnt == $past(r_cnt) + 1'b1), "step counter skipped")

endmodule

// ===== hdl/pwg_sine_rom.sv =====
// Sine lookup from a quarter-wave constant table, registered read.
`timescale 1ns / 1ps

module pwg_sine_rom import pwg_pkg::*; (
    input  logic                     i_clk,
    input  logic [PHASE_W-1:0]       i_phase,
    output logic signed [SINE_W-1:0] o_sine
);

    logic [QUARTER_W-1:0]     w_rem;
    logic [QUARTER_W-1:0]     w_idx;
    logic signed [SINE_W-1:0] w_mag;
    logic signed [SINE_W-1:0] r_sine;

    always_comb begin
        w_rem = i_phase[QUARTER_W-1:0];
        w_idx = w_rem;
        w_mag = SINE_QUARTER[w_idx];
        if (i_phase[QUARTER_W]) begin
            // falling quarter, mirrored index; its start is the peak
            w_idx = ~w_rem + QUARTER_W'(1);
            w_mag = (w_rem == '0) ? SINE_PEAK : SINE_QUARTER[w_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        r_sine <= i_phase[PHASE_W-1] ? -w_mag : w_mag;
    end

    assign o_sine = r_sine;

endmodule

// ===== hdl/pwg_out_reg.sv =====
// Output register holding one finished sample until the sink takes it.
`timescale 1ns / 1ps

module pwg_out_reg import pwg_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    input  logic signed [SAMPLE_W-1:0] i_sample,
    output logic                       o_ready,
    pwg_out_if.source                  o_out
);

    logic                       r_valid;
    logic signed [SAMPLE_W-1:0] r_sample;

    assign o_ready = !r_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_sample <= i_sample;
        end
    end

    assign o_out.valid  = r_valid;
    assign o_out.sample = r_sample;

endmodule

// ===== hdl/periodic_waveform_generator_core.sv =====
// Top level: step, ramp and sine waveform generator driven by time step items.
//
//  channel  | dir | handshake    | payload
//  ---------+-----+--------------+---------------------------
//  i_in     | in  | valid/ready  | time_step  16b unsigned
//  o_out    | out | valid/ready  | sample     32b signed
//  i_cfg    | in  | valid/ready  | index 4b, data 32b
//
// One item at a time. Step mode and zero results pass through ACC, WRAP, DIFF and FORM;
// ramp adds MUL before FORM; sine adds DIV (the 43-step radix-2 phase divider) and MUL.
// i_rst_n is synchronous, active low; registers with a reset take their reset values at the clock edge.
// A finished sample waits in the output register; the next item is taken
// once the core is back in idle, and the core holds in FORM while that register is full and the sink is not ready.
`timescale 1ns / 1ps
`include "periodic_waveform_generator_core_assert.svh"

module periodic_waveform_generator_core import pwg_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    pwg_in_if.sink     i_in,
    pwg_out_if.source  o_out,
    pwg_cfg_if.sink    i_cfg
);

    t_state r_state;
    t_state n_state;

    logic [MODE_W-1:0]       r_mode;
    logic signed [AMP_W-1:0] r_amp;
    logic [TICKS_W-1:0]      r_delay;
    logic [TICKS_W-1:0]      r_period;

    logic [ELAPSED_W-1:0]      r_elapsed;
    logic [ELAPSED_W-1:0]      n_elapsed;
    t_kind                     r_kind;
    t_kind                     n_kind;
    t_kind                     w_kind;
    logic [TIME_STEP_W-1:0]    r_step;
    logic [ELAPSED_W-1:0]      r_diff;
    logic signed [PROD_W-1:0]  r_prod;

    logic                       w_in_accept;
    logic [ELAPSED_W:0]         w_sum;
    logic [ELAPSED_W:0]         w_diff;
    logic                       w_pos;
    logic signed [ELAPSED_W:0]  w_mul_a;
    logic signed [PROD_W-1:0]   w_prod;
    logic signed [SINE_W-1:0]   w_sine;
    logic signed [SAMPLE_W-1:0] w_result;
    logic                       w_res_valid;
    logic                       w_res_ready;
    t_div_req                   w_div_req;
    t_div_rsp                   w_div_rsp;

    assign i_in.ready  = (r_state == ST_IDLE);
    assign w_in_accept = i_in.valid && i_in.ready;
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_STEP;
            r_amp    <= '0;
            r_delay  <= '0;
            r_period <= PERIOD_RESET;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_MODE:      r_mode   <= i_cfg.data[MODE_W-1:0];
                CFG_AMPLITUDE: r_amp    <= i_cfg.data[AMP_W-1:0];
                CFG_DELAY:     r_delay  <= i_cfg.data[TICKS_W-1:0];
                CFG_PERIOD:    r_period <= i_cfg.data[TICKS_W-1:0];
                default: ;
            endcase
        end
    end

    assign w_sum  = {1'b0, r_elapsed} + (ELAPSED_W+1)'(r_step);
    assign w_diff = {1'b0, r_elapsed} - (ELAPSED_W+1)'(r_delay);
    assign w_pos  = !w_diff[ELAPSED_W] && (w_diff != '0);

    always_comb begin
        w_kind = KIND_ZERO;
        if (w_pos) begin
            case (r_mode)
                MODE_STEP: w_kind = KIND_STEP;
                MODE_RAMP: w_kind = KIND_RAMP;
                MODE_SINE: w_kind = (r_period != '0) ? KIND_SINE : KIND_ZERO;
                default:   w_kind = KIND_ZERO;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state            = r_state;
        n_elapsed          = r_elapsed;
        n_kind             = r_kind;
        w_div_req.start    = 1'b0;
        w_div_req.dividend = w_diff[ELAPSED_W-1:0];
        w_res_valid        = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (w_in_accept) begin
                    n_state = ST_ACC;
                end
            end
            ST_ACC: begin
                n_elapsed = w_sum[ELAPSED_W] ? {ELAPSED_W{1'b1}} : w_sum[ELAPSED_W-1:0];
                n_state   = ST_WRAP;
            end
            ST_WRAP: begin
                if (r_elapsed > ELAPSED_W'(r_period)) begin
                    n_elapsed = r_elapsed - ELAPSED_W'(r_period);
                end
                n_state = ST_DIFF;
            end
            ST_DIFF: begin
                n_kind = w_kind;
                case (w_kind)
                    KIND_SINE: begin
                        w_div_req.start = 1'b1;
                        n_state         = ST_DIV;
                    end
                    KIND_RAMP: n_state = ST_MUL;
                    default:   n_state = ST_FORM;
                endcase
            end
            ST_DIV: begin
                if (w_div_rsp.done) begin
                    n_state = ST_MUL;
                end
            end
            ST_MUL: begin
                n_state = ST_FORM;
            end
            ST_FORM: begin
                w_res_valid = 1'b1;
                if (w_res_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_elapsed <= '0;
            r_kind    <= KIND_ZERO;
        end else begin
            r_elapsed <= n_elapsed;
            r_kind    <= n_kind;
        end
    end

    // Shared multiplier: ramp uses r_diff, sine uses the table value.
    assign w_mul_a = (r_kind == KIND_SINE) ? (ELAPSED_W+1)'(w_sine)
                                           : signed'({1'b0, r_diff});
    assign w_prod  = PROD_W'(w_mul_a) * PROD_W'(r_amp);

    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_step <= i_in.time_step;
        end
        if (r_state == ST_DIFF) begin
            r_diff <= w_diff[ELAPSED_W-1:0];
        end
        if (r_state == ST_MUL) begin
            r_prod <= w_prod;
        end
    end

    always_comb begin
        case (r_kind)
            KIND_STEP: w_result = SAMPLE_W'(r_amp);
            KIND_RAMP: begin
                if ((r_prod[PROD_W-1:SAMPLE_W-1] == '0) || (r_prod[PROD_W-1:SAMPLE_W-1] == '1)) begin
                    w_result = r_prod[SAMPLE_W-1:0];
                end else begin
                    w_result = r_prod[PROD_W-1] ? SAMPLE_MIN : SAMPLE_MAX;
                end
            end
            KIND_SINE: w_result = r_prod[SINE_FRAC+SAMPLE_W-1:SINE_FRAC];
            default:   w_result = '0;
        endcase
    end

    pwg_phase_div u_phase_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (w_div_req),
        .i_divisor (r_period),
        .o_rsp     (w_div_rsp)
    );

    pwg_sine_rom u_sine_rom (
        .i_clk   (i_clk),
        .i_phase (w_div_rsp.phase),
        .o_sine  (w_sine)
    );

    pwg_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_res_valid),
        .i_sample (w_result),
        .o_ready  (w_res_ready),
        .o_out    (o_out)
    );

    `PWG_ASSERT_NEXT(a_accept_starts, i_clk, i_rst_n, w_in_accept, r_state == ST_ACC, "item accepted but core did not start")
    `PWG_ASSERT(a_done_in_div, i_clk, i_rst_n, !w_div_rsp.done || (r_state == ST_DIV), "divider result outside divide state")
    `PWG_ASSERT_NEXT(a_handoff_idle, i_clk, i_rst_n, w_res_valid && w_res_ready, r_state == ST_IDLE, "core not idle after handoff")

endmodule
